// File: rtl/core/fat12te_pkg.sv
`default_nettype none

package fat12te_pkg;

  // table geometry
  localparam int Clusters   = 3072;
  localparam int TableDepth = 4608;
  localparam int RowCount   = TableDepth / 3;
  localparam int RowW       = $clog2(RowCount);

  // field widths
  localparam int CmdW      = 3;
  localparam int ClusterW  = 12;
  localparam int EntryW    = 12;
  localparam int ByteAddrW = 13;
  localparam int ByteW     = 8;
  localparam int RowDataW  = 3 * ByteW;

  localparam logic [ClusterW-1:0] LimitReset = ClusterW'(Clusters);
  localparam logic [EntryW-1:0]   EndMark    = 12'hfff;

  // divide by three through a reciprocal: valid for addresses below the table depth
  localparam int                  Div3Shift = 13;
  localparam logic [11:0]         Div3Recip = 12'd2731;
  localparam int                  ProdW     = ByteAddrW + 12;

  typedef enum logic [CmdW-1:0] {
    CMD_RD_ENTRY = 3'd0,
    CMD_WR_ENTRY = 3'd1,
    CMD_ALLOC    = 3'd2,
    CMD_RD_BYTE  = 3'd3,
    CMD_WR_BYTE  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [EntryW-1:0] entry_out;
    logic [ByteW-1:0]  byte_out;
    logic              table_full;
    logic              bad_index;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/fat12te_cmd_if.sv
`default_nettype none

interface fat12te_cmd_if import fat12te_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CmdW-1:0]      command;
  logic [ClusterW-1:0]  cluster;
  logic [EntryW-1:0]    entry_value;
  logic [ByteAddrW-1:0] byte_address;
  logic [ByteW-1:0]     byte_data;

  modport source (output valid, command, cluster, entry_value, byte_address, byte_data,
                  input ready);
  modport sink (input valid, command, cluster, entry_value, byte_address, byte_data,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/fat12te_rsp_if.sv
`default_nettype none

interface fat12te_rsp_if import fat12te_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EntryW-1:0] entry_out;
  logic [ByteW-1:0]  byte_out;
  logic              table_full;
  logic              bad_index;

  modport source (output valid, entry_out, byte_out, table_full, bad_index, input ready);
  modport sink (input valid, entry_out, byte_out, table_full, bad_index, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fat12te_cfg_if.sv
`default_nettype none

interface fat12te_cfg_if import fat12te_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ClusterW-1:0] cluster_limit;

  modport source (output valid, cluster_limit, input ready);
  modport sink (input valid, cluster_limit, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fat12_table_engine_unit.sv
// FAT12 allocation table engine.
// cmd_i carries one command per transfer: read entry, write entry, allocate,
// read byte or write byte. rsp_o returns exactly one result per command.
// cfg_i writes the allocation scan limit; it is always ready. The user must write
// it only while no command is in flight; the block itself does not enforce this.
// The table lives in one synchronous memory of 1536 rows, each row holding
// the three packed bytes shared by an even and an odd entry.
// Entry and byte commands pass from the command transfer to the result in
// the output register through accept, memory read, and modify with write
// back; an out-of-range or unknown command finishes straight from accept. Allocation
// reads one row (two clusters) per cycle until a free entry or the limit.
// One command is processed at a time; the single memory read port and its
// read-modify-write sets the rate.
// Reset clears the control state and sets the scan limit to 3072; the table
// content is undefined until loaded through byte or entry writes.
// When the receiver stalls, the result waits in the output register while
// the next command is processed; that command then holds its result until
// the output register is free.
`default_nettype none

module fat12_table_engine_unit import fat12te_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  fat12te_cmd_if.sink    cmd_i,
  fat12te_rsp_if.source  rsp_o,
  fat12te_cfg_if.sink    cfg_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MOD  = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic                odd_q, odd_d;
  logic [EntryW-1:0]   val_q, val_d;
  logic [ByteAddrW-1:0] addr_q, addr_d;
  logic [ByteW-1:0]    data_q, data_d;
  logic [RowW-1:0]     row_q, row_d;
  logic                chk_valid_q, chk_valid_d;
  logic [RowW-1:0]     chk_row_q, chk_row_d;
  result_t             res_q, res_d, res_new, out_res_q;
  logic                out_valid_q;
  logic [ClusterW-1:0] limit_q;

  logic                accept, finish, out_free, out_load;
  result_t             out_load_res;
  logic [ClusterW-1:0] lim;
  logic [ProdW-1:0]    byte_prod;
  logic [RowW-1:0]     byte_row;
  logic [ByteAddrW-1:0] lane_full;
  logic [1:0]          lane;

  // table memory
  logic [RowDataW-1:0] mem_q [RowCount];
  logic                rd_en, wr_en;
  logic [RowW-1:0]     rd_addr, wr_addr;
  logic [RowDataW-1:0] rdata_q, wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.cluster_limit;
    end
  end

  assign lim = (limit_q > ClusterW'(Clusters)) ? ClusterW'(Clusters) : limit_q;

  // byte address to row by reciprocal multiply
  assign byte_prod = ProdW'(cmd_i.byte_address) * ProdW'(Div3Recip);
  assign byte_row  = byte_prod[Div3Shift +: RowW];

  // lane within the row from registered address and row
  assign lane_full = addr_q - ByteAddrW'({row_q, 1'b0}) - ByteAddrW'(row_q);
  assign lane      = lane_full[1:0];

  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;

  // command sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    odd_d       = odd_q;
    val_d       = val_q;
    addr_d      = addr_q;
    data_d      = data_q;
    row_d       = row_q;
    chk_valid_d = chk_valid_q;
    chk_row_d   = chk_row_q;
    res_d       = res_q;
    res_new     = '0;
    finish      = 1'b0;
    out_load    = 1'b0;
    out_load_res = res_q;
    rd_en       = 1'b0;
    rd_addr     = row_q;
    wr_en       = 1'b0;
    wr_addr     = row_q;
    wr_data     = rdata_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d  = cmd_e'(cmd_i.command);
          odd_d  = cmd_i.cluster[0];
          val_d  = cmd_i.entry_value;
          addr_d = cmd_i.byte_address;
          data_d = cmd_i.byte_data;
          case (cmd_e'(cmd_i.command))
            CMD_RD_ENTRY, CMD_WR_ENTRY: begin
              if (cmd_i.cluster < ClusterW'(Clusters)) begin
                row_d   = cmd_i.cluster[ClusterW-1:1];
                state_d = S_READ;
              end else begin
                res_new.bad_index = 1'b1;
                finish = 1'b1;
              end
            end
            CMD_ALLOC: begin
              row_d       = RowW'(1);
              chk_valid_d = 1'b0;
              if (lim > ClusterW'(2)) begin
                state_d = S_SCAN;
              end else begin
                res_new.table_full = 1'b1;
                finish = 1'b1;
              end
            end
            CMD_RD_BYTE, CMD_WR_BYTE: begin
              if (cmd_i.byte_address < ByteAddrW'(TableDepth)) begin
                row_d   = byte_row;
                state_d = S_READ;
              end else begin
                res_new.bad_index = 1'b1;
                finish = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_MOD;
      end

      S_MOD: begin
        finish = 1'b1;
        case (cmd_q)
          CMD_RD_ENTRY: begin
            res_new.entry_out = odd_q ? rdata_q[RowDataW-1:EntryW] : rdata_q[EntryW-1:0];
          end
          CMD_WR_ENTRY: begin
            wr_en = 1'b1;
            if (odd_q) begin
              wr_data = {val_q, rdata_q[EntryW-1:0]};
            end else begin
              wr_data = {rdata_q[RowDataW-1:EntryW], val_q};
            end
          end
          CMD_RD_BYTE: begin
            case (lane)
              2'd0:    res_new.byte_out = rdata_q[7:0];
              2'd1:    res_new.byte_out = rdata_q[15:8];
              2'd2:    res_new.byte_out = rdata_q[23:16];
              default: res_new.byte_out = '0;
            endcase
          end
          CMD_WR_BYTE: begin
            wr_en = 1'b1;
            case (lane)
              2'd0:    wr_data = {rdata_q[23:8], data_q};
              2'd1:    wr_data = {rdata_q[23:16], data_q, rdata_q[7:0]};
              2'd2:    wr_data = {data_q, rdata_q[15:0]};
              default: wr_data = rdata_q;
            endcase
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
      end

      S_SCAN: begin
        // issue the next row while its even cluster is below the limit
        if (ClusterW'({row_q, 1'b0}) < lim) begin
          rd_en       = 1'b1;
          rd_addr     = row_q;
          row_d       = row_q + RowW'(1);
          chk_valid_d = 1'b1;
          chk_row_d   = row_q;
        end else begin
          chk_valid_d = 1'b0;
        end
        // check the row read in the previous cycle
        if (chk_valid_q) begin
          wr_addr = chk_row_q;
          if (rdata_q[EntryW-1:0] == '0) begin
            wr_en = 1'b1;
            wr_data = {rdata_q[RowDataW-1:EntryW], EndMark};
            res_new.entry_out = EntryW'({chk_row_q, 1'b0});
            finish = 1'b1;
          end else if (rdata_q[RowDataW-1:EntryW] == '0 &&
                       ClusterW'({chk_row_q, 1'b1}) < lim) begin
            wr_en = 1'b1;
            wr_data = {EndMark, rdata_q[EntryW-1:0]};
            res_new.entry_out = EntryW'({chk_row_q, 1'b1});
            finish = 1'b1;
          end else if (ByteAddrW'({chk_row_q, 1'b0}) + ByteAddrW'(2) >=
                       ByteAddrW'(lim)) begin
            res_new.table_full = 1'b1;
            finish = 1'b1;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          out_load_res = res_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // hand the result to the output register or park it
    if (finish) begin
      if (out_free) begin
        out_load = 1'b1;
        out_load_res = res_new;
        state_d = S_IDLE;
      end else begin
        res_d = res_new;
        state_d = S_DONE;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_valid_q <= chk_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    odd_q     <= odd_d;
    val_q     <= val_d;
    addr_q    <= addr_d;
    data_q    <= data_d;
    row_q     <= row_d;
    chk_row_q <= chk_row_d;
    res_q     <= res_d;
    if (out_load) begin
      out_res_q <= out_load_res;
    end
  end

  // result channel
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.entry_out  = out_res_q.entry_out;
  assign rsp_o.byte_out   = out_res_q.byte_out;
  assign rsp_o.table_full = out_res_q.table_full;
  assign rsp_o.bad_index  = out_res_q.bad_index;

endmodule

`default_nettype wire

// File: tb/fat12te_tb_pkg.sv
`default_nettype none

package fat12te_tb_pkg;
  import fat12te_pkg::*;

  // reserved command codes, they leave the table alone
  localparam logic [CmdW-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CmdW-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CmdW-1:0] CMD_RSVD_7 = 3'd7;

  // largest number of mismatch lines printed
  localparam int unsigned PrintCap = 40;

  typedef struct packed {
    logic [CmdW-1:0]      command;
    logic [ClusterW-1:0]  cluster;
    logic [EntryW-1:0]    entry_value;
    logic [ByteAddrW-1:0] byte_address;
    logic [ByteW-1:0]     byte_data;
  } fat_cmd_t;

  // shadow copy of the packed table plus the results it predicts
  class fat_table_shadow;
    logic [ByteW-1:0]    image [TableDepth];
    logic [ClusterW-1:0] scan_limit;
    result_t             expected_q [$];
    int unsigned         mismatches;
    int unsigned         results_seen;
    int unsigned         full_seen;
    int unsigned         bad_seen;
    int unsigned         by_command [8];

    function new();
      image        = '{default: '0};
      scan_limit   = LimitReset;
      mismatches   = 0;
      results_seen = 0;
      full_seen    = 0;
      bad_seen     = 0;
      by_command   = '{default: 0};
    endfunction

    function bit cluster_in_range(int unsigned n);
      return (n < Clusters) && ((n / 2) * 3 + 2 < TableDepth);
    endfunction

    // even entries own the low byte and low nibble, odd ones the high nibble and high byte
    function logic [EntryW-1:0] entry_of(int unsigned n);
      int unsigned b;
      b = (n / 2) * 3;
      if (n % 2) return {image[b+2], image[b+1][7:4]};
      return {image[b+1][3:0], image[b]};
    endfunction

    function void store_entry(int unsigned n, logic [EntryW-1:0] v);
      int unsigned b;
      b = (n / 2) * 3;
      if (n % 2) begin
        image[b+1][7:4] = v[3:0];
        image[b+2]      = v[11:4];
      end else begin
        image[b]        = v[7:0];
        image[b+1][3:0] = v[11:8];
      end
    endfunction

    // an accepted command: update the shadow table and queue its result
    function void apply_command(fat_cmd_t c);
      result_t     r;
      int unsigned lim;
      int unsigned n;
      bit          found;
      r     = '0;
      found = 1'b0;
      by_command[c.command]++;
      case (c.command)
        CMD_RD_ENTRY: begin
          if (cluster_in_range(c.cluster)) r.entry_out = entry_of(c.cluster);
          else r.bad_index = 1'b1;
        end
        CMD_WR_ENTRY: begin
          if (cluster_in_range(c.cluster)) store_entry(c.cluster, c.entry_value);
          else r.bad_index = 1'b1;
        end
        CMD_ALLOC: begin
          lim = (scan_limit > Clusters) ? Clusters : scan_limit;
          for (n = 2; n < lim && !found && cluster_in_range(n); n++) begin
            if (entry_of(n) == '0) begin
              store_entry(n, EndMark);
              r.entry_out = EntryW'(n);
              found       = 1'b1;
            end
          end
          r.table_full = !found;
        end
        CMD_RD_BYTE: begin
          if (c.byte_address < TableDepth) r.byte_out = image[c.byte_address];
          else r.bad_index = 1'b1;
        end
        CMD_WR_BYTE: begin
          if (c.byte_address < TableDepth) image[c.byte_address] = c.byte_data;
          else r.bad_index = 1'b1;
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= PrintCap) $display("MISMATCH result %0d: %s", results_seen, what);
    endfunction

    // compare one returned result with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("no result pending, got %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (want.table_full) full_seen++;
      if (want.bad_index) bad_seen++;
      if (got.entry_out !== want.entry_out)
        report($sformatf("entry_out %h, want %h", got.entry_out, want.entry_out));
      if (got.byte_out !== want.byte_out)
        report($sformatf("byte_out %h, want %h", got.byte_out, want.byte_out));
      if (got.table_full !== want.table_full)
        report($sformatf("table_full %b, want %b", got.table_full, want.table_full));
      if (got.bad_index !== want.bad_index)
        report($sformatf("bad_index %b, want %b", got.bad_index, want.bad_index));
    endfunction
  endclass

endpackage

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fat12te_pkg::*;
  import fat12te_tb_pkg::*;

  // head of the table that is loaded; in-range random stimulus stays inside it
  localparam int LoadBytes    = 96;
  localparam int LoadClusters = LoadBytes / 3 * 2;

  logic clk = 1'b0;
  logic rst_n;

  fat12te_cmd_if cmd_if ();
  fat12te_rsp_if rsp_if ();
  fat12te_cfg_if cfg_if ();

  fat12_table_engine_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  fat_table_shadow shadow = new();

  int unsigned send_idle_pct  = 10;
  int unsigned recv_stall_pct = 63;
  int unsigned limits_used    = 0;
  bit          long_hold_req  = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned hold_left      = 0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: check every transfer, then pick the next ready
  initial begin
    result_t got;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        got.entry_out  = rsp_if.entry_out;
        got.byte_out   = rsp_if.byte_out;
        got.table_full = rsp_if.table_full;
        got.bad_index  = rsp_if.bad_index;
        shadow.check_result(got);
      end
      if (long_hold_req && !long_hold_done) begin
        hold_left      = 300;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one command transfer, with random idle cycles ahead of it
  task automatic send_command(fat_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.command      <= c.command;
    cmd_if.cluster      <= c.cluster;
    cmd_if.entry_value  <= c.entry_value;
    cmd_if.byte_address <= c.byte_address;
    cmd_if.byte_data    <= c.byte_data;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    shadow.apply_command(c);
  endtask

  // stop offering and wait for every pending result
  task automatic quiesce();
    cmd_if.valid <= 1'b0;
    while (shadow.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(int unsigned v);
    cfg_if.valid         <= 1'b1;
    cfg_if.cluster_limit <= ClusterW'(v);
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    shadow.scan_limit = ClusterW'(v);
    limits_used++;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic fat_cmd_t make_cmd(logic [CmdW-1:0] op, int unsigned clus,
                                        int unsigned val, int unsigned addr,
                                        int unsigned data);
    fat_cmd_t c;
    c.command      = op;
    c.cluster      = ClusterW'(clus);
    c.entry_value  = EntryW'(val);
    c.byte_address = ByteAddrW'(addr);
    c.byte_data    = ByteW'(data);
    return c;
  endfunction

  // weighted command mix, in range means inside the loaded head, zero writes free clusters
  function automatic fat_cmd_t random_command();
    fat_cmd_t    c;
    int unsigned pick;
    c.cluster      = ($urandom_range(7) == 0) ? ClusterW'($urandom_range(4095, Clusters))
                                              : ClusterW'($urandom_range(LoadClusters - 1));
    c.entry_value  = ($urandom_range(3) == 0) ? '0 : EntryW'($urandom_range(4095));
    c.byte_address = ($urandom_range(7) == 0) ? ByteAddrW'($urandom_range(8191, TableDepth))
                                              : ByteAddrW'($urandom_range(LoadBytes - 1));
    c.byte_data    = ByteW'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 25)      c.command = CMD_RD_ENTRY;
    else if (pick < 50) c.command = CMD_WR_ENTRY;
    else if (pick < 70) c.command = CMD_ALLOC;
    else if (pick < 81) c.command = CMD_RD_BYTE;
    else if (pick < 92) c.command = CMD_WR_BYTE;
    else if (pick < 95) c.command = CMD_RSVD_5;
    else if (pick < 98) c.command = CMD_RSVD_6;
    else                c.command = CMD_RSVD_7;
    return c;
  endfunction

  // stimulus
  initial begin
    int unsigned limit_plan [3][3];
    int unsigned a;
    rst_n                <= 1'b0;
    cmd_if.valid         <= 1'b0;
    cmd_if.command       <= CMD_RD_ENTRY;
    cmd_if.cluster       <= '0;
    cmd_if.entry_value   <= '0;
    cmd_if.byte_address  <= '0;
    cmd_if.byte_data     <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.cluster_limit <= '0;
    // zero in the plan means a random limit
    limit_plan = '{'{LoadClusters, 3, 0}, '{24, LoadClusters, 0}, '{0, 3, LoadClusters}};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load the table head; reads stay inside it or in rows written before
    write_limit(Clusters);
    for (a = 0; a < LoadBytes; a++)
      send_command(make_cmd(CMD_WR_BYTE, $urandom_range(4095), $urandom_range(4095), a,
                            ($urandom_range(2) == 0) ? 0 : $urandom_range(255)));

    // directed: field extremes, last pair of entries, range errors, allocations, reserved codes
    send_command(make_cmd(CMD_RD_ENTRY, 0, 0, 0, 0));
    send_command(make_cmd(CMD_RD_ENTRY, 1, 4095, 8191, 255));
    send_command(make_cmd(CMD_WR_ENTRY, Clusters - 2, 12'hfff, 0, 0));
    send_command(make_cmd(CMD_WR_ENTRY, Clusters - 1, 12'habc, 0, 0));
    send_command(make_cmd(CMD_RD_ENTRY, Clusters - 2, 0, 0, 0));
    send_command(make_cmd(CMD_RD_ENTRY, Clusters - 1, 0, 0, 0));
    send_command(make_cmd(CMD_RD_ENTRY, Clusters, 0, 0, 0));
    send_command(make_cmd(CMD_RD_ENTRY, 4095, 4095, 8191, 255));
    send_command(make_cmd(CMD_RD_BYTE, 0, 0, TableDepth - 2, 0));
    send_command(make_cmd(CMD_RD_BYTE, 0, 0, TableDepth - 1, 0));
    send_command(make_cmd(CMD_WR_ENTRY, 4095, 12'h123, 0, 0));
    send_command(make_cmd(CMD_WR_ENTRY, 2, 0, 0, 0));
    send_command(make_cmd(CMD_ALLOC, 0, 0, 0, 0));
    send_command(make_cmd(CMD_WR_ENTRY, 3, 0, 0, 0));
    send_command(make_cmd(CMD_ALLOC, 4095, 4095, 8191, 255));
    send_command(make_cmd(CMD_RD_BYTE, 0, 0, 0, 0));
    send_command(make_cmd(CMD_RD_BYTE, 0, 0, TableDepth, 0));
    send_command(make_cmd(CMD_RD_BYTE, 0, 0, 8191, 0));
    send_command(make_cmd(CMD_WR_BYTE, 0, 0, TableDepth - 1, 0));
    send_command(make_cmd(CMD_WR_BYTE, 0, 0, 8191, 255));
    send_command(make_cmd(CMD_WR_BYTE, 0, 0, 0, 255));
    send_command(make_cmd(CMD_RSVD_5, 4095, 4095, 8191, 255));
    send_command(make_cmd(CMD_RSVD_6, 0, 0, 0, 0));
    send_command(make_cmd(CMD_RSVD_7, 2, 0, 4, 0));

    // limit above the cluster count is clamped
    quiesce();
    write_limit(4095);
    send_command(make_cmd(CMD_WR_ENTRY, 5, 0, 0, 0));
    send_command(make_cmd(CMD_ALLOC, 0, 0, 0, 0));
    send_command(make_cmd(CMD_RD_ENTRY, 5, 0, 0, 0));

    // smallest limit: only cluster 2 may be handed out
    quiesce();
    write_limit(3);
    send_command(make_cmd(CMD_ALLOC, 0, 0, 0, 0));
    send_command(make_cmd(CMD_WR_ENTRY, 2, 0, 0, 0));
    send_command(make_cmd(CMD_ALLOC, 0, 0, 0, 0));

    // random phases over three idle patterns and several limits
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 10; recv_stall_pct = 63; end
        1: begin send_idle_pct = 63; recv_stall_pct = 10; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int step = 0; step < 3; step++) begin
        quiesce();
        write_limit((limit_plan[mode][step] == 0) ? $urandom_range(LoadClusters, 3)
                                                  : limit_plan[mode][step]);
        // one long receiver hold while commands keep coming
        if (mode == 0 && step == 0) long_hold_req = 1'b1;
        repeat (36) send_command(random_command());
      end
    end

    quiesce();
    repeat (16) @(posedge clk);
    $display("run covered %0d results over %0d scan limits, table head loaded first",
             shadow.results_seen, limits_used);
    $display("entry rd %0d wr %0d, alloc %0d (%0d full), byte rd %0d wr %0d, %0d out of range",
             shadow.by_command[CMD_RD_ENTRY], shadow.by_command[CMD_WR_ENTRY],
             shadow.by_command[CMD_ALLOC], shadow.full_seen, shadow.by_command[CMD_RD_BYTE],
             shadow.by_command[CMD_WR_BYTE], shadow.bad_seen);
    if (shadow.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/fat12te_pkg.sv
rtl/core/fat12te_cmd_if.sv
rtl/core/fat12te_rsp_if.sv
rtl/core/fat12te_cfg_if.sv
rtl/core/fat12_table_engine_unit.sv
tb/fat12te_tb_pkg.sv
tb/tb_top.sv
